FILE: rtl/core/tmcw_pkg.sv
// Shared types and constants for the text-mode console writer.
// Used by tmcw_ctrl, tmcw_dpath and text_mode_console_writer_top; no dependencies.
package tmcw_pkg;

   // command function codes carried in the request
   localparam logic [2:0] FUNC_PUT    = 3'd0;
   localparam logic [2:0] FUNC_CLEAR  = 3'd1;
   localparam logic [2:0] FUNC_SETCUR = 3'd2;
   localparam logic [2:0] FUNC_BLANK  = 3'd3;
   localparam logic [2:0] FUNC_READ   = 3'd4;

   localparam logic [7:0]  SPACE_CHAR   = 8'h20;
   localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0]  RESET_ATTR   = 8'h07;
   localparam logic [15:0] RESET_CELL   = 16'h0720;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_FILL_ROW,
      ST_FILL_ALL,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_PUT,
      OP_CLEAR_START,
      OP_SETCUR,
      OP_BLANK_START,
      OP_READ,
      OP_SCROLL_RD,
      OP_SCROLL_WR,
      OP_FILL,
      OP_RESPOND
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      fill_init;   // fill with the reset cell instead of attribute spaces
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       put_scrolls;
      logic       sw_col_last;
      logic       sw_row_last;
      logic       scroll_src_last;
      logic       rsp_free;
   } dp_status_type;

endpackage

FILE: rtl/core/text_mode_console_writer_top.sv
// Top level of the text-mode console writer: sequencer plus datapath.
// Depends on tmcw_pkg, tmcw_ctrl and tmcw_dpath.
//
// Usage: one command transaction on req_* gives exactly one response on rsp_*.
// Commands: put char (newline moves down), clear screen, set cursor (clamped),
// blank current row, read cell. csr_we/csr_wdata set the attribute byte used
// for written characters and blanked cells; write it only while no command is in flight.
// Commands run one at a time. Put char without a scroll, set cursor and read
// cell pass through EXEC and RESP before rsp_tvalid rises; read cell does one
// registered memory read. req_tready comes back in the same cycle as rsp_tvalid,
// so a new command is only taken once the last response is loaded. A put char
// that scrolls copies each cell of rows 1 to ROWS-1 up one row, one read and
// one write per cell, then blanks the bottom row. Clear screen sweeps every
// cell, blank row the cursor row. After reset the cell memory is swept to grey
// spaces, req_tready low until the sweep ends; cursor goes to 0,0, attribute to 0x07.
// The response sits in an output register. While the receiver stalls, one more
// command is taken and executed; it then waits for that register to empty, and
// req_tready stays low until its own response has been loaded.
module text_mode_console_writer_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // func[2:0], char_code[10:3], col[17:11], row[22:18], pad
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,   // text_attribute
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // cell_data[15:0], cursor_col[22:16],
                                    // cursor_row[27:23], scrolled[28], pad
);

   tmcw_pkg::dp_cmd_type    cmd;
   tmcw_pkg::dp_status_type status;

   tmcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tmcw_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

   // one command at a time: acceptance closes the request side
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted twice in a row");

   // a scroll always leaves the cursor at column 0 of the last row
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[28] |->
         (rsp_tdata[22:16] == 7'd0) && (rsp_tdata[27:23] == 5'(ROWS - 1)))
      else $error("scroll with cursor off the bottom row start");

   // cursor column stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[22:16]) < COLUMNS))
      else $error("cursor column past screen width");

endmodule

FILE: rtl/core/tmcw_ctrl.sv
// Sequencer for the text-mode console writer: decodes the captured command and
// steps the datapath through writes, sweeps and scrolls. Depends on tmcw_pkg.
module tmcw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  tmcw_pkg::dp_status_type status,
   output tmcw_pkg::dp_cmd_type    cmd
);

   tmcw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmcw_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmcw_pkg::ST_INIT: begin
            if (status.sw_col_last && status.sw_row_last) state_in = tmcw_pkg::ST_IDLE;
         end
         tmcw_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = tmcw_pkg::ST_EXEC;
         end
         tmcw_pkg::ST_EXEC: begin
            unique case (status.func)
               tmcw_pkg::FUNC_PUT: begin
                  state_in = status.put_scrolls ? tmcw_pkg::ST_SCROLL_RD : tmcw_pkg::ST_RESP;
               end
               tmcw_pkg::FUNC_CLEAR: state_in = tmcw_pkg::ST_FILL_ALL;
               tmcw_pkg::FUNC_BLANK: state_in = tmcw_pkg::ST_FILL_ROW;
               default:              state_in = tmcw_pkg::ST_RESP;
            endcase
         end
         tmcw_pkg::ST_SCROLL_RD: state_in = tmcw_pkg::ST_SCROLL_WR;
         tmcw_pkg::ST_SCROLL_WR: begin
            // last source row copied: bottom row gets blanked next
            if (status.sw_col_last && status.scroll_src_last) begin
               state_in = tmcw_pkg::ST_FILL_ROW;
            end else begin
               state_in = tmcw_pkg::ST_SCROLL_RD;
            end
         end
         tmcw_pkg::ST_FILL_ROW: begin
            if (status.sw_col_last) state_in = tmcw_pkg::ST_RESP;
         end
         tmcw_pkg::ST_FILL_ALL: begin
            if (status.sw_col_last && status.sw_row_last) state_in = tmcw_pkg::ST_RESP;
         end
         tmcw_pkg::ST_RESP: begin
            if (status.rsp_free) state_in = tmcw_pkg::ST_IDLE;
         end
         default: state_in = tmcw_pkg::ST_INIT;
      endcase
   end

   // datapath commands
   always_comb begin
      req_tready    = 1'b0;
      cmd.op        = tmcw_pkg::OP_NONE;
      cmd.fill_init = 1'b0;
      unique case (state_ff)
         tmcw_pkg::ST_INIT: begin
            cmd.op        = tmcw_pkg::OP_FILL;
            cmd.fill_init = 1'b1;
         end
         tmcw_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = tmcw_pkg::OP_CAPTURE;
         end
         tmcw_pkg::ST_EXEC: begin
            unique case (status.func)
               tmcw_pkg::FUNC_PUT:    cmd.op = tmcw_pkg::OP_PUT;
               tmcw_pkg::FUNC_CLEAR:  cmd.op = tmcw_pkg::OP_CLEAR_START;
               tmcw_pkg::FUNC_SETCUR: cmd.op = tmcw_pkg::OP_SETCUR;
               tmcw_pkg::FUNC_BLANK:  cmd.op = tmcw_pkg::OP_BLANK_START;
               tmcw_pkg::FUNC_READ:   cmd.op = tmcw_pkg::OP_READ;
               default:               cmd.op = tmcw_pkg::OP_NONE;
            endcase
         end
         tmcw_pkg::ST_SCROLL_RD: cmd.op = tmcw_pkg::OP_SCROLL_RD;
         tmcw_pkg::ST_SCROLL_WR: cmd.op = tmcw_pkg::OP_SCROLL_WR;
         tmcw_pkg::ST_FILL_ROW:  cmd.op = tmcw_pkg::OP_FILL;
         tmcw_pkg::ST_FILL_ALL:  cmd.op = tmcw_pkg::OP_FILL;
         tmcw_pkg::ST_RESP: begin
            if (status.rsp_free) cmd.op = tmcw_pkg::OP_RESPOND;
         end
         default: cmd.op = tmcw_pkg::OP_NONE;
      endcase
   end

endmodule

FILE: rtl/core/tmcw_dpath.sv
// Datapath for the text-mode console writer: cell memory, cursor, attribute
// register, sweep counters and the response register. Depends on tmcw_pkg.
module tmcw_dpath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tmcw_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                csr_we,
   input  logic [7:0]                          csr_wdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [tmcw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  tmcw_pkg::dp_cmd_type                cmd,
   output tmcw_pkg::dp_status_type             status
);

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = ROWS * (2 ** COL_W);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [ROW_W-1:0] SRC_LAST = ROW_W'(ROWS - 2);

   // row-major cell store, address is {row, column}
   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   logic [2:0]       cap_func_ff;
   logic [7:0]       cap_char_ff;
   logic [COL_W-1:0] cap_col_ff, cap_col_in;
   logic [ROW_W-1:0] cap_row_ff, cap_row_in;

   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [COL_W-1:0] sw_col_ff, sw_col_in;
   logic [ROW_W-1:0] sw_row_ff, sw_row_in;
   logic             scrolled_ff, scrolled_in;
   logic [7:0]       attr_ff;
   logic             rsp_valid_ff;
   logic [tmcw_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [15:0]       mem_wdata;
   logic              is_newline, wrap, put_scrolls, sweep_step;
   logic [15:0]       cell_out;

   logic [2:0] req_func;
   logic [7:0] req_char;
   logic [6:0] req_col;
   logic [4:0] req_row;

   assign req_func = req_tdata[2:0];
   assign req_char = req_tdata[10:3];
   assign req_col  = req_tdata[17:11];
   assign req_row  = req_tdata[22:18];

   // clamp coordinates to the screen
   always_comb begin
      if (int'(req_col) > COLUMNS - 1) cap_col_in = COL_LAST;
      else                             cap_col_in = COL_W'(req_col);
      if (int'(req_row) > ROWS - 1)    cap_row_in = ROW_LAST;
      else                             cap_row_in = ROW_W'(req_row);
   end

   assign is_newline  = (cap_char_ff == tmcw_pkg::NEWLINE_CHAR);
   assign wrap        = (cur_col_ff == COL_LAST) || is_newline;
   assign put_scrolls = wrap && (cur_row_ff == ROW_LAST);
   assign sweep_step  = (cmd.op == tmcw_pkg::OP_FILL) || (cmd.op == tmcw_pkg::OP_SCROLL_WR);

   // cursor, sweep counters and scroll flag
   always_comb begin
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      sw_col_in   = sw_col_ff;
      sw_row_in   = sw_row_ff;
      scrolled_in = scrolled_ff;
      case (cmd.op)
         tmcw_pkg::OP_CAPTURE: scrolled_in = 1'b0;
         tmcw_pkg::OP_PUT: begin
            if (wrap) begin
               cur_col_in = '0;
               if (put_scrolls) begin
                  scrolled_in = 1'b1;
                  sw_col_in   = '0;
                  sw_row_in   = '0;
               end else begin
                  cur_row_in = cur_row_ff + 1'b1;
               end
            end else begin
               cur_col_in = cur_col_ff + 1'b1;
            end
         end
         tmcw_pkg::OP_CLEAR_START: begin
            sw_col_in = '0;
            sw_row_in = '0;
         end
         tmcw_pkg::OP_SETCUR: begin
            cur_col_in = cap_col_ff;
            cur_row_in = cap_row_ff;
         end
         tmcw_pkg::OP_BLANK_START: begin
            cur_col_in = '0;
            sw_col_in  = '0;
            sw_row_in  = cur_row_ff;
         end
         default: begin
            if (sweep_step) begin
               if (sw_col_ff == COL_LAST) begin
                  sw_col_in = '0;
                  sw_row_in = sw_row_ff + 1'b1;
               end else begin
                  sw_col_in = sw_col_ff + 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         sw_col_ff    <= '0;
         sw_row_ff    <= '0;
         scrolled_ff  <= 1'b0;
         attr_ff      <= tmcw_pkg::RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_col_ff  <= cur_col_in;
         cur_row_ff  <= cur_row_in;
         sw_col_ff   <= sw_col_in;
         sw_row_ff   <= sw_row_in;
         scrolled_ff <= scrolled_in;
         if (csr_we) attr_ff <= csr_wdata;
         if (cmd.op == tmcw_pkg::OP_RESPOND) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                 rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.op == tmcw_pkg::OP_CAPTURE) begin
         cap_func_ff <= req_func;
         cap_char_ff <= req_char;
         cap_col_ff  <= cap_col_in;
         cap_row_ff  <= cap_row_in;
      end
      if (cmd.op == tmcw_pkg::OP_RESPOND) begin
         rsp_data_ff <= {3'b000, scrolled_ff, 5'(cur_row_ff), 7'(cur_col_ff), cell_out};
      end
   end

   assign cell_out = (cap_func_ff == tmcw_pkg::FUNC_READ) ? rd_data_ff : 16'h0000;

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = {sw_row_ff, sw_col_ff};
      mem_raddr = {cap_row_ff, cap_col_ff};
      mem_wdata = cmd.fill_init ? tmcw_pkg::RESET_CELL : {attr_ff, tmcw_pkg::SPACE_CHAR};
      case (cmd.op)
         tmcw_pkg::OP_PUT: begin
            mem_we    = !is_newline;
            mem_waddr = {cur_row_ff, cur_col_ff};
            mem_wdata = {attr_ff, cap_char_ff};
         end
         tmcw_pkg::OP_FILL: mem_we = 1'b1;
         tmcw_pkg::OP_SCROLL_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff;
         end
         tmcw_pkg::OP_SCROLL_RD: begin
            mem_re    = 1'b1;
            mem_raddr = {ROW_W'(sw_row_ff + 1'b1), sw_col_ff};
         end
         tmcw_pkg::OP_READ: mem_re = 1'b1;
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   assign status.func            = cap_func_ff;
   assign status.put_scrolls     = put_scrolls;
   assign status.sw_col_last     = (sw_col_ff == COL_LAST);
   assign status.sw_row_last     = (sw_row_ff == ROW_LAST);
   assign status.scroll_src_last = (sw_row_ff == SRC_LAST);
   assign status.rsp_free        = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
